FILE: rtl/svng_pkg.sv
// Shared constants and types for the seeded value noise generator.
`timescale 1ns / 1ps
`default_nettype none
package svng_pkg;

  // Octaves summed by the walk shape
  localparam int OCTAVE_COUNT = 4;
  localparam int LANE_COUNT   = 2 * OCTAVE_COUNT;

  // Sample format, signed Q1.23
  localparam int Q_W = 24;
  typedef logic signed [Q_W-1:0] q_t;

  // Hash constants
  localparam logic [31:0] MIX_C1   = 32'h7feb352d;
  localparam logic [31:0] MIX_C2   = 32'h846ca68b;
  localparam logic [31:0] GOLDEN   = 32'h9e3779b9;
  localparam logic [31:0] OCT_STEP = 32'd7919;

  // Position formats: t is Q28.28, shifted by up to three octaves
  localparam int BEAT_W = 40;
  localparam int RATE_W = 16;
  localparam int TQ_W   = BEAT_W + RATE_W;
  localparam int TSH_W  = 64;

  // Walk division by the weight total, by reciprocal multiply
  localparam int ACC_W   = Q_W + OCTAVE_COUNT;
  localparam int TOTAL   = (1 << OCTAVE_COUNT) - 1;
  localparam int DIV_L   = $clog2(TOTAL);
  localparam int DIV_SH  = ACC_W + DIV_L;
  localparam int DIV_M_W = ACC_W + 1;
  localparam logic [63:0] DIV_M_WIDE = ((64'd1 << DIV_SH) + 64'(TOTAL) - 64'd1) / 64'(TOTAL);
  localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'(DIV_M_WIDE);

  // Register stages from input capture to output register
  localparam int PIPE_DEPTH = 12;

  // Noise shape codes
  localparam logic [1:0] SHAPE_PER_NOTE = 2'd0;
  localparam logic [1:0] SHAPE_OCTAVES  = 2'd1;
  localparam logic [1:0] SHAPE_SMOOTH   = 2'd2;

  // Register map
  typedef enum logic [1:0] {
    REG_NOISE_SHAPE = 2'd0,
    REG_DRIFT_RATE  = 2'd1,
    REG_EVOLVE_MODE = 2'd2
  } reg_idx_t;

endpackage
`default_nettype wire

FILE: rtl/svng_if.sv
// Valid/ready channel interfaces for query and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface svng_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] chart_seed;
  logic [31:0] pass_number;
  logic [39:0] beat_position;
  logic [31:0] note_index;

  modport source (output valid, chart_seed, pass_number, beat_position, note_index,
                  input ready);
  modport sink   (input valid, chart_seed, pass_number, beat_position, note_index,
                  output ready);
endinterface

interface svng_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface
`default_nettype wire

FILE: rtl/svng_mix.sv
// Two-stage pipelined 32-bit lowbias mixer.
`timescale 1ns / 1ps
`default_nettype none
module svng_mix (
  input  logic        clk,
  input  logic        adv,
  input  logic [31:0] x,
  output logic [31:0] y
);
  import svng_pkg::*;

  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] m1_r;
  logic [31:0] m2_r;

  // First fold and multiply
  assign a = x ^ (x >> 16);
  // Second fold and multiply
  assign b = m1_r ^ (m1_r >> 15);

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r <= a * MIX_C1;
      m2_r <= b * MIX_C2;
    end
  end

  // Final fold
  assign y = m2_r ^ (m2_r >> 16);

endmodule
`default_nettype wire

FILE: rtl/svng_blend.sv
// Smoothstep weight and lattice blend for one octave.
`timescale 1ns / 1ps
`default_nettype none
module svng_blend (
  input  logic           clk,
  input  logic           adv,
  input  logic [23:0]    fr,
  input  logic [31:0]    hash_a,
  input  logic [31:0]    hash_b,
  output svng_pkg::q_t   n_val,
  output svng_pkg::q_t   lat_a
);
  import svng_pkg::*;

  logic [23:0] fr_r;
  logic [23:0] f2_r;
  logic [25:0] shp;
  logic [49:0] f2w;
  logic [24:0] w_r;
  logic [24:0] w_pipe_r [4];
  q_t          a_r;
  q_t          b_r;
  logic [25:0] d_wide;
  logic [24:0] d;
  logic [49:0] dw_r;
  q_t          a8_r;
  logic [24:0] w8_r;
  logic signed [26:0] n_wide;
  q_t          n_r;
  q_t          la_r;
  logic [47:0] fsq;

  assign fsq    = 48'(fr) * 48'(fr);
  assign shp    = 26'(3 << 24) - {1'b0, fr_r, 1'b0};
  assign f2w    = 50'(f2_r) * 50'(shp);
  assign d_wide = 26'($signed({b_r[23], b_r[23], b_r}) - $signed({a_r[23], a_r[23], a_r}))
                  + 26'(1 << 24);
  assign d      = d_wide[24:0];
  assign n_wide = $signed({{3{a8_r[23]}}, a8_r}) + $signed({1'b0, dw_r[49:24]})
                  - $signed({2'b00, w8_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      // Square the fraction
      fr_r <= fr;
      f2_r <= fsq[47:24];
      // Smoothstep weight
      w_r  <= f2w[48:24];
      // Hold the weight until the lattice values arrive
      w_pipe_r[0] <= w_r;
      w_pipe_r[1] <= w_pipe_r[0];
      w_pipe_r[2] <= w_pipe_r[1];
      w_pipe_r[3] <= w_pipe_r[2];
      // Lattice values, top 24 hash bits less the bias
      a_r <= {~hash_a[31], hash_a[30:8]};
      b_r <= {~hash_b[31], hash_b[30:8]};
      // Biased difference times weight
      dw_r <= 50'(d) * 50'(w_pipe_r[3]);
      a8_r <= a_r;
      w8_r <= w_pipe_r[3];
      // Blend result
      n_r  <= n_wide[23:0];
      la_r <= a8_r;
    end
  end

  assign n_val = n_r;
  assign lat_a = la_r;

endmodule
`default_nettype wire

FILE: rtl/svng_walk.sv
// Octave sum, division by the weight total, saturation and shape select.
`timescale 1ns / 1ps
`default_nettype none
module svng_walk (
  input  logic         clk,
  input  logic         adv,
  input  logic [1:0]   shape,
  input  svng_pkg::q_t n_val [svng_pkg::OCTAVE_COUNT],
  input  svng_pkg::q_t lat0,
  output svng_pkg::q_t noise
);
  import svng_pkg::*;

  logic [ACC_W-1:0]         acc_nxt;
  logic [ACC_W-1:0]         acc_r;
  q_t                       direct_r;
  logic [ACC_W+DIV_M_W-1:0] prod_r;
  q_t                       direct2_r;
  logic [ACC_W-1:0]         quo;
  q_t                       walk_val;
  q_t                       noise_r;

  // Weighted sum of biased octave values
  always_comb begin
    acc_nxt = '0;
    for (int o = 0; o < OCTAVE_COUNT; o++) begin
      acc_nxt = acc_nxt + (ACC_W'({~n_val[o][Q_W-1], n_val[o][Q_W-2:0]})
                           << (OCTAVE_COUNT - 1 - o));
    end
  end

  // Quotient, debiased and saturated
  assign quo = prod_r[DIV_SH +: ACC_W];
  always_comb begin
    if (quo > ACC_W'((1 << Q_W) - 1)) begin
      walk_val = {1'b0, {(Q_W-1){1'b1}}};
    end else begin
      walk_val = {~quo[Q_W-1], quo[Q_W-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r     <= acc_nxt;
      direct_r  <= (shape == SHAPE_SMOOTH) ? n_val[0] : lat0;
      prod_r    <= (ACC_W+DIV_M_W)'(acc_r) * (ACC_W+DIV_M_W)'(DIV_M);
      direct2_r <= direct_r;
      if (shape == SHAPE_PER_NOTE || shape == SHAPE_SMOOTH) begin
        noise_r <= direct2_r;
      end else begin
        noise_r <= walk_val;
      end
    end
  end

  assign noise = noise_r;

endmodule
`default_nettype wire

FILE: rtl/seeded_value_noise_generator_core.sv
// Top level of the seeded value noise generator: config registers and pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Stateless noise source: each query beat (seed, pass, position, note index)
// yields one signed Q1.23 result beat. A new query is taken every cycle while
// the output is not stalled. The query passes through registered multipliers:
// the rate and pass products, the key mixer and each lane's inner mixer, both
// feeding that lane's outer mixer, the smoothstep weight, the blend product
// and the reciprocal divide for the walk. A stalled output holds the whole
// pipeline, nothing is lost.
// Registers: 0x0 noise_shape, 0x4 drift_rate, 0x8 evolve_mode; change them
// only while no query is in flight.
module seeded_value_noise_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  svng_in_if.sink     in_ch,
  svng_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import svng_pkg::*;

  logic [1:0]            shape_r;
  logic [RATE_W-1:0]     rate_r;
  logic                  evolve_r;
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [31:0]           seed1_r;
  logic [31:0]           pm1_r;
  logic [TQ_W-1:0]       tq1_r;
  logic [31:0]           nidx1_r;
  logic [31:0]           k0;
  logic [31:0]           key_y;
  logic [31:0]           pos2_r   [LANE_COUNT];
  logic [31:0]           inner_y  [LANE_COUNT];
  logic [31:0]           key_o_r  [OCTAVE_COUNT];
  logic [31:0]           hash_y   [LANE_COUNT];
  logic [31:0]           lat_pos  [OCTAVE_COUNT];
  logic [23:0]           fr       [OCTAVE_COUNT];
  q_t                    n_val    [OCTAVE_COUNT];
  q_t                    lat_a    [OCTAVE_COUNT];
  q_t                    noise;
  reg_idx_t              idx;

  // Configuration port
  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r  <= SHAPE_PER_NOTE;
      rate_r   <= RATE_W'(4096);
      evolve_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_NOISE_SHAPE: shape_r  <= pwdata[1:0];
        REG_DRIFT_RATE:  rate_r   <= pwdata[RATE_W-1:0];
        REG_EVOLVE_MODE: evolve_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NOISE_SHAPE: prdata = {30'd0, shape_r};
      REG_DRIFT_RATE:  prdata = {16'd0, rate_r};
      REG_EVOLVE_MODE: prdata = {31'd0, evolve_r};
      default:         prdata = 32'd0;
    endcase
  end

  // Advance the whole pipeline unless the output beat is stalled
  assign adv          = !vld_r[PIPE_DEPTH-1] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = vld_r[PIPE_DEPTH-1];
  assign out_ch.noise_value = noise;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_ch.valid};
    end
  end

  // Capture the query with the pass and rate products
  always_ff @(posedge clk) begin
    if (adv) begin
      seed1_r <= in_ch.chart_seed;
      pm1_r   <= in_ch.pass_number * GOLDEN;
      tq1_r   <= TQ_W'(in_ch.beat_position) * TQ_W'(rate_r);
      nidx1_r <= in_ch.note_index;
    end
  end

  // Seed hash
  assign k0 = seed1_r ^ (evolve_r ? pm1_r : 32'd0);

  svng_mix u_key_mix (
    .clk (clk),
    .adv (adv),
    .x   (k0),
    .y   (key_y)
  );

  // Lattice cells and fractions per octave
  always_comb begin
    for (int o = 0; o < OCTAVE_COUNT; o++) begin
      logic [TSH_W-1:0] ts;
      ts         = TSH_W'(tq1_r) << o;
      lat_pos[o] = ts[59:28];
      fr[o]      = ts[27:4];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int o = 0; o < OCTAVE_COUNT; o++) begin
        pos2_r[2*o+1] <= lat_pos[o] + 32'd1;
        key_o_r[o]    <= key_y + 32'(o) * OCT_STEP;
      end
      // White noise keys the first lane on the note index
      pos2_r[0] <= (shape_r == SHAPE_PER_NOTE) ? nidx1_r : lat_pos[0];
      for (int o = 1; o < OCTAVE_COUNT; o++) begin
        pos2_r[2*o] <= lat_pos[o];
      end
    end
  end

  // Per lane: hash the position, fold in the octave key, hash again
  for (genvar j = 0; j < LANE_COUNT; j++) begin : g_lane
    svng_mix u_inner (
      .clk (clk),
      .adv (adv),
      .x   (pos2_r[j]),
      .y   (inner_y[j])
    );
    svng_mix u_outer (
      .clk (clk),
      .adv (adv),
      .x   (key_o_r[j/2] ^ inner_y[j]),
      .y   (hash_y[j])
    );
  end

  // Per octave blend
  for (genvar o = 0; o < OCTAVE_COUNT; o++) begin : g_oct
    svng_blend u_blend (
      .clk    (clk),
      .adv    (adv),
      .fr     (fr[o]),
      .hash_a (hash_y[2*o]),
      .hash_b (hash_y[2*o+1]),
      .n_val  (n_val[o]),
      .lat_a  (lat_a[o])
    );
  end

  svng_walk u_walk (
    .clk   (clk),
    .adv   (adv),
    .shape (shape_r),
    .n_val (n_val),
    .lat0  (lat_a[0]),
    .noise (noise)
  );

endmodule
`default_nettype wire
